// File: hdl/pstbp_pkg.sv
package pstbp_pkg;

    localparam int DEF_ENTRIES = 256;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 63;
    localparam int TOK_W   = 56;
    localparam int RATE_W  = 24;
    localparam int BURST_W = 25;
    localparam int CAP_W   = 9;
    localparam int TTL_W   = 16;
    localparam int CFG_W   = 25;
    localparam int MUL_W   = 32;

    // One whole token in scaled units.
    localparam logic [29:0] ONE_TOKEN = 30'd1000000000;
    localparam logic [TTL_W-1:0] DEF_TTL_S = 16'd30;

    typedef enum logic [1:0] {
        CFG_RATE  = 2'd0,
        CFG_BURST = 2'd1,
        CFG_CAP   = 2'd2,
        CFG_TTL   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MOD,
        S_MOD1,
        S_MOD2,
        S_TTL,
        S_THR,
        S_SCAN,
        S_DECIDE,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_H5,
        S_C0,
        S_C1,
        S_TAKE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TOK_W-1:0]   tokens;
        logic [TIME_W-1:0]  refill;
        logic [TIME_W-1:0]  seen;
        logic [RATE_W-1:0]  rate;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic   en;
        logic   set_valid;
        t_entry data;
    } t_tbl_wr;

endpackage

// File: hdl/pstbp_mul.sv
module pstbp_mul (
    input  logic                            i_clk,
    input  logic [pstbp_pkg::MUL_W-1:0]     i_a,
    input  logic [pstbp_pkg::MUL_W-1:0]     i_b,
    output logic [2*pstbp_pkg::MUL_W-1:0]   o_p
);
    import pstbp_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    // Registered product; the sequencer reads it in the cycle after it sets up the operands.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: hdl/pstbp_table.sv
module pstbp_table #(
    parameter int ENTRIES = pstbp_pkg::DEF_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_idx,
    output pstbp_pkg::t_entry           o_rd_entry,
    output logic                        o_rd_valid,
    input  pstbp_pkg::t_tbl_wr          i_wr,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_idx
);
    import pstbp_pkg::*;

    t_entry               mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;
    t_entry               r_rd_entry;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr_idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_entry <= mem[i_rd_idx];
        end
    end

    // Valid bits live in flip-flops so reset empties the table at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en && i_wr.set_valid) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

// File: hdl/per_source_token_bucket_policer.sv
// Per-source token bucket policer.
// An arrival beat (source address and nanosecond timestamp) is taken at a rising
// edge where i_start is high and o_busy is low. The block answers with one result
// beat: o_done is high for exactly one cycle with o_allowed, o_created_entry and
// o_evicted_entry valid in that cycle. The receiver cannot stall; it must take the
// beat when o_done is high. o_busy stays high while an arrival is being worked on.
// With rate zero the answer comes the cycle after the start. Otherwise, on one
// shared 32x32 multiplier, the sequencer runs a reciprocal multiply for the home
// slot in S_MOD to S_MOD2 (skipped when the table size is a power of two), TTL
// arithmetic in S_TTL and S_THR, a full probe scan of every slot through the
// single table read port in S_SCAN, a decision state, refill arithmetic in S_H0
// to S_H5 for a known source or bucket creation in S_C0 and S_C1 for a new one,
// and a write-back state; the result strobe follows in the next cycle, and the
// next arrival can be taken at the edge that ends the strobe cycle.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the
// user must write it only while the block is idle, which the block itself does
// not enforce. Reset clears the valid bits, the tracked source count, rate and
// burst, sets the peer cap to 256 and TTL to its default; table needs no clear.
module per_source_token_bucket_policer #(
    parameter int TABLE_ENTRIES = pstbp_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [pstbp_pkg::ADDR_W-1:0]    i_source_address,
    input  logic [pstbp_pkg::TIME_W-1:0]    i_arrival_time_ns,
    output logic                            o_done,
    output logic                            o_allowed,
    output logic                            o_created_entry,
    output logic                            o_evicted_entry,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pstbp_pkg::CFG_W-1:0]     i_cfg_data
);
    import pstbp_pkg::*;

    localparam int  IW   = $clog2(TABLE_ENTRIES);
    localparam int  CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int  CMPW = (CW > CAP_W + 1) ? CW : CAP_W + 1;
    localparam bit  POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    // Truncated reciprocal of the table size; the quotient estimate it gives is
    // at most one short, so a single compare and subtract finishes the remainder.
    localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << MUL_W) / 64'(TABLE_ENTRIES));

    // Configuration registers.
    logic [RATE_W-1:0]  r_rate;
    logic [BURST_W-1:0] r_burst;
    logic [CAP_W-1:0]   r_peer_cap;
    logic [TTL_W-1:0]   r_ttl;

    t_state r_state, n_state;

    // Arrival being worked on.
    logic [ADDR_W-1:0]  r_addr;
    logic [TIME_W-1:0]  r_now;

    // Home slot computation.
    logic [IW-1:0]      r_home;
    logic [ADDR_W-1:0]  mod_diff;

    // Scan state.
    logic [CW-1:0]      r_cnt;
    logic [IW-1:0]      r_pidx;
    logic [IW-1:0]      r_ridx;
    logic               r_rd_ok;
    logic               r_hit;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_exp_en;
    logic [TIME_W-1:0]  r_thr;
    logic               r_exp_found;
    logic [IW-1:0]      r_exp_idx;
    logic               r_lru_found;
    logic [IW-1:0]      r_lru_idx;
    logic [TIME_W-1:0]  r_lru_seen;

    // Bucket arithmetic.
    t_entry             r_ent;
    logic [IW-1:0]      r_slot;
    logic               r_create;
    logic               r_evict;
    logic [BURST_W-1:0] r_beff;
    logic [TIME_W-1:0]  r_el;
    logic               r_doref;
    logic [TOK_W-1:0]   r_cur;
    logic [TOK_W-1:0]   r_maxt;
    logic [TOK_W-1:0]   r_room;
    logic               r_full;
    logic [79:0]        r_acc;
    logic               r_big;
    logic               r_over;
    logic [CW-1:0]      r_count;

    // Shared multiplier.
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;

    // Table ports.
    logic               tbl_rd_en;
    t_entry             tbl_rd_entry;
    logic               tbl_rd_valid;
    t_tbl_wr            tbl_wr;

    logic [TTL_W-1:0]   ttl_eff;
    logic [BURST_W-1:0] beff;
    logic [CMPW-1:0]    cap_eff;
    logic [CMPW-1:0]    pc_ext;
    logic               below_cap;
    logic               accept;
    logic               take_ok;
    logic [TOK_W-1:0]   tok_after;

    assign accept  = i_start && !o_busy;
    assign ttl_eff = (r_ttl == '0) ? DEF_TTL_S : r_ttl;
    assign beff    = (r_burst != '0) ? r_burst : {r_rate, 1'b0};

    // A cap of zero or any value beyond the table size means the whole table.
    assign pc_ext    = CMPW'(r_peer_cap);
    assign cap_eff   = (pc_ext == '0 || pc_ext > CMPW'(TABLE_ENTRIES)) ?
                       CMPW'(TABLE_ENTRIES) : pc_ext;
    assign below_cap = CMPW'(r_count) < cap_eff;

    // Address minus the estimated quotient times the table size; below twice
    // the table size by construction of the reciprocal.
    assign mod_diff = r_addr - mul_p[ADDR_W-1:0];

    assign take_ok   = r_cur >= TOK_W'(ONE_TOKEN);
    assign tok_after = take_ok ? r_cur - TOK_W'(ONE_TOKEN) : r_cur;

    pstbp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pstbp_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (tbl_rd_en),
        .i_rd_idx   (r_pidx),
        .o_rd_entry (tbl_rd_entry),
        .o_rd_valid (tbl_rd_valid),
        .i_wr       (tbl_wr),
        .i_wr_idx   (r_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, multiplier operand selection and table control.
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        tbl_rd_en = 1'b0;
        tbl_wr    = '0;
        o_busy    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (accept && r_rate != '0) begin
                    n_state = POW2 ? S_TTL : S_MOD;
                end
            end
            S_MOD: begin
                mul_a   = MUL_W'(r_addr);
                mul_b   = RECIP;
                n_state = S_MOD1;
            end
            S_MOD1: begin
                mul_a   = mul_p[2*MUL_W-1:MUL_W];
                mul_b   = MUL_W'(TABLE_ENTRIES);
                n_state = S_MOD2;
            end
            S_MOD2: begin
                n_state = S_TTL;
            end
            S_TTL: begin
                mul_a   = MUL_W'(ttl_eff);
                mul_b   = MUL_W'(ONE_TOKEN);
                n_state = S_THR;
            end
            S_THR: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                tbl_rd_en = (r_cnt < CW'(TABLE_ENTRIES));
                if (r_cnt == CW'(TABLE_ENTRIES)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = r_hit ? S_H0 : S_C0;
            end
            S_H0: begin
                mul_a   = MUL_W'(r_ent.burst);
                mul_b   = MUL_W'(ONE_TOKEN);
                n_state = S_H1;
            end
            S_H1: begin
                mul_a   = MUL_W'(r_ent.rate);
                mul_b   = MUL_W'(r_el[27:0]);
                n_state = S_H2;
            end
            S_H2: begin
                mul_a   = MUL_W'(r_ent.rate);
                mul_b   = MUL_W'(r_el[54:28]);
                n_state = S_H3;
            end
            S_H3: begin
                n_state = S_H4;
            end
            S_H4: begin
                n_state = S_H5;
            end
            S_H5: begin
                n_state = S_TAKE;
            end
            S_C0: begin
                mul_a   = MUL_W'(beff);
                mul_b   = MUL_W'(ONE_TOKEN);
                n_state = S_C1;
            end
            S_C1: begin
                n_state = S_TAKE;
            end
            S_TAKE: begin
                tbl_wr.en             = 1'b1;
                tbl_wr.set_valid      = r_create;
                tbl_wr.data.addr      = r_create ? r_addr : r_ent.addr;
                tbl_wr.data.rate      = r_create ? r_rate : r_ent.rate;
                tbl_wr.data.burst     = r_create ? r_beff : r_ent.burst;
                tbl_wr.data.refill    = (r_create || r_doref) ? r_now : r_ent.refill;
                tbl_wr.data.seen      = r_now;
                tbl_wr.data.tokens    = tok_after;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration and control registers, all set by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= '0;
            r_burst    <= '0;
            r_peer_cap <= CAP_W'(256);
            r_ttl      <= DEF_TTL_S;
            r_count    <= '0;
            r_rd_ok    <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RATE:  r_rate     <= i_cfg_data[RATE_W-1:0];
                    CFG_BURST: r_burst    <= i_cfg_data[BURST_W-1:0];
                    CFG_CAP:   r_peer_cap <= i_cfg_data[CAP_W-1:0];
                    CFG_TTL:   r_ttl      <= i_cfg_data[TTL_W-1:0];
                    default:   r_ttl      <= r_ttl;
                endcase
            end
            r_rd_ok <= tbl_rd_en;
            o_done  <= (r_state == S_TAKE) || (accept && r_rate == '0);
            if (r_state == S_TAKE && r_create && !r_evict) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_addr          <= i_source_address;
                    r_now           <= i_arrival_time_ns;
                    r_home          <= i_source_address[IW-1:0];
                    o_allowed       <= 1'b1;
                    o_created_entry <= 1'b0;
                    o_evicted_entry <= 1'b0;
                end
            end
            S_MOD2: begin
                r_home <= (mod_diff >= ADDR_W'(TABLE_ENTRIES)) ?
                          IW'(mod_diff - ADDR_W'(TABLE_ENTRIES)) : IW'(mod_diff);
            end
            S_TTL: begin
                r_pidx       <= r_home;
                r_cnt        <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_exp_found  <= 1'b0;
                r_lru_found  <= 1'b0;
            end
            S_THR: begin
                // An entry is stale when its seen time is below now minus the TTL.
                r_exp_en <= r_now > TIME_W'(mul_p[45:0]);
                r_thr    <= r_now - TIME_W'(mul_p[45:0]);
            end
            S_SCAN: begin
                if (tbl_rd_en) begin
                    r_ridx <= r_pidx;
                    r_pidx <= (r_pidx == IW'(TABLE_ENTRIES - 1)) ? '0 : r_pidx + 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_rd_ok) begin
                    if (tbl_rd_valid && tbl_rd_entry.addr == r_addr) begin
                        r_hit  <= 1'b1;
                        r_ent  <= tbl_rd_entry;
                        r_slot <= r_ridx;
                    end
                    if (!tbl_rd_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_ridx;
                    end
                    if (tbl_rd_valid && r_exp_en && tbl_rd_entry.seen < r_thr &&
                        (!r_exp_found || r_ridx < r_exp_idx)) begin
                        r_exp_found <= 1'b1;
                        r_exp_idx   <= r_ridx;
                    end
                    if (tbl_rd_valid && (!r_lru_found || tbl_rd_entry.seen < r_lru_seen ||
                        (tbl_rd_entry.seen == r_lru_seen && r_ridx < r_lru_idx))) begin
                        r_lru_found <= 1'b1;
                        r_lru_idx   <= r_ridx;
                        r_lru_seen  <= tbl_rd_entry.seen;
                    end
                end
            end
            S_DECIDE: begin
                r_create <= !r_hit;
            end
            S_H0: begin
                r_el    <= r_now - r_ent.refill;
                r_doref <= r_now > r_ent.refill;
                r_cur   <= r_ent.tokens;
                r_evict <= 1'b0;
            end
            S_H1: begin
                r_maxt <= mul_p[TOK_W-1:0];
            end
            S_H2: begin
                r_full <= r_cur >= r_maxt;
                r_room <= r_maxt - r_cur;
                r_acc  <= 80'(mul_p);
                r_big  <= r_el[TIME_W-1:55] != '0;
            end
            S_H3: begin
                r_acc <= r_acc + (80'(mul_p) << 28);
            end
            S_H4: begin
                // rate * elapsed beyond the room left fills the bucket.
                r_over <= r_big || (r_acc > 80'(r_room));
            end
            S_H5: begin
                if (r_doref) begin
                    if (r_full || r_over) begin
                        r_cur <= r_maxt;
                    end else if (r_ent.rate != '0) begin
                        r_cur <= r_cur + r_acc[TOK_W-1:0];
                    end
                end
            end
            S_C0: begin
                r_beff <= beff;
                if (below_cap && r_free_found) begin
                    r_slot  <= r_free_idx;
                    r_evict <= 1'b0;
                end else if (r_exp_found) begin
                    r_slot  <= r_exp_idx;
                    r_evict <= 1'b1;
                end else if (r_lru_found) begin
                    r_slot  <= r_lru_idx;
                    r_evict <= 1'b1;
                end else begin
                    r_slot  <= r_home;
                    r_evict <= 1'b0;
                end
            end
            S_C1: begin
                r_cur <= mul_p[TOK_W-1:0];
            end
            S_TAKE: begin
                o_allowed       <= take_ok;
                o_created_entry <= r_create;
                o_evicted_entry <= r_evict;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAKE |=> o_done)
        else $error("result strobe missing after bucket update");

    a_evict_creates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_evicted_entry |-> o_created_entry)
        else $error("eviction without a new bucket");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("tracked source count beyond table size");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAKE && r_create && !r_evict |=> r_count == $past(r_count) + 1'b1)
        else $error("source count did not grow on a fresh bucket");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> o_busy && !o_done)
        else $error("result or idle seen during the probe scan");

endmodule
